@@ rtl/satellite_record_table_assert.svh @@
// assertion macros for the satellite record table
// no dependencies; taken in by satellite_record_table, which checks its own logic
`ifndef SATELLITE_RECORD_TABLE_ASSERT_SVH
`define SATELLITE_RECORD_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication check
`define SRT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srt check failed");
// next-cycle implication check
`define SRT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srt check failed");
`else
`define SRT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SRT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/srt_pkg.sv @@
// shared types, codes and constants of the satellite record table
// no dependencies
package srt_pkg;

   // default table depth
   localparam int SlotsDef = 16;

   // config register reset values
   localparam logic [31:0] RecycleReset = 32'd60000;
   localparam logic [31:0] RecentReset  = 32'd10000;

   // config port address width
   localparam int CsrAddrW = 3;

   // command codes, the fourth code is ignored
   typedef enum logic [1:0] {
      CmdTick   = 2'd0,
      CmdUpdate = 2'd1,
      CmdQuery  = 2'd2
   } cmd_type;

   // config register index
   typedef enum logic [0:0] {
      RegRecycle = 1'b0,
      RegRecent  = 1'b1
   } reg_idx_type;

   // record payload
   typedef struct packed {
      logic [7:0]        sat_number;
      logic signed [7:0] elevation;
      logic [8:0]        azimuth;
      logic [6:0]        snr;
   } rec_type;

   // contents of one table cell
   typedef struct packed {
      logic        valid;
      rec_type     rec;
      logic [31:0] stamp;
   } cell_word_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shift;
      logic wr;
   } cell_ctrl_type;

endpackage

@@ rtl/srt_req_if.sv @@
// request channel of the satellite record table
// no dependencies
interface srt_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [7:0]        sat_number;
   logic signed [7:0] elevation;
   logic [8:0]        azimuth;
   logic [6:0]        snr;

   modport source (output valid, cmd, sat_number, elevation, azimuth, snr, input ready);
   modport sink (input valid, cmd, sat_number, elevation, azimuth, snr, output ready);
endinterface

@@ rtl/srt_rsp_if.sv @@
// response channel of the satellite record table
// no dependencies
interface srt_rsp_if;
   logic              valid;
   logic              ready;
   logic              record_valid;
   logic [7:0]        out_sat_number;
   logic signed [7:0] out_elevation;
   logic [8:0]        out_azimuth;
   logic [6:0]        out_snr;
   logic              last;

   modport source (output valid, record_valid, out_sat_number, out_elevation,
                    out_azimuth, out_snr, last, input ready);
   modport sink (input valid, record_valid, out_sat_number, out_elevation,
                 out_azimuth, out_snr, last, output ready);
endinterface

@@ rtl/srt_cell.sv @@
// one table cell: holds a record, loads it from its neighbor when the ring rotates
// depends on srt_pkg
module srt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  srt_pkg::cell_ctrl_type ctrl,
   input  srt_pkg::cell_word_type nbr_word,
   input  srt_pkg::cell_word_type wr_word,
   output srt_pkg::cell_word_type word
);

   logic                valid_ff;
   srt_pkg::rec_type    rec_ff;
   logic [31:0]         stamp_ff;

   // occupancy bit, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.wr) begin
         valid_ff <= 1'b1;
      end else if (ctrl.shift) begin
         valid_ff <= nbr_word.valid;
      end
   end

   // record and stamp
   always_ff @(posedge clock) begin
      if (ctrl.wr) begin
         rec_ff   <= wr_word.rec;
         stamp_ff <= wr_word.stamp;
      end else if (ctrl.shift) begin
         rec_ff   <= nbr_word.rec;
         stamp_ff <= nbr_word.stamp;
      end
   end

   assign word.valid = valid_ff;
   assign word.rec   = rec_ff;
   assign word.stamp = stamp_ff;

endmodule

@@ rtl/srt_csr.sv @@
// config registers of the satellite record table behind an apb-style port
// depends on srt_pkg
module srt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [srt_pkg::CsrAddrW-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output logic [31:0]                   recycle_ticks,
   output logic [31:0]                   recent_ticks
);

   logic [31:0]          recycle_ff;
   logic [31:0]          recent_ff;
   srt_pkg::reg_idx_type sel_idx;
   logic                 wr_go;

   assign sel_idx = srt_pkg::reg_idx_type'(paddr[2]);
   assign wr_go   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         recycle_ff <= srt_pkg::RecycleReset;
         recent_ff  <= srt_pkg::RecentReset;
      end else if (wr_go) begin
         case (sel_idx)
            srt_pkg::RegRecycle: begin
               recycle_ff <= pwdata;
            end
            srt_pkg::RegRecent: begin
               recent_ff <= pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   // read back
   always_comb begin
      case (sel_idx)
         srt_pkg::RegRecycle: prdata = recycle_ff;
         srt_pkg::RegRecent:  prdata = recent_ff;
         default:             prdata = '0;
      endcase
   end

   assign recycle_ticks = recycle_ff;
   assign recent_ticks  = recent_ff;

endmodule

@@ rtl/satellite_record_table.sv @@
// An update goes through accept, one rotation of the cell ring past the head cell,
// and write; a query goes through accept, one rotation of the ring, which may stall
// while the response side is not ready, and a final word. Ticks and ignored words go one
// a cycle while the table is idle; no request is taken while an update or query runs.
// Reset clears the time counter and all occupancy bits at once (no clearing pass)
// and loads recycle_ticks 60000 and recent_ticks 10000.
module satellite_record_table #(
   parameter int SLOTS = srt_pkg::SlotsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   srt_req_if.sink                      req_bus,
   srt_rsp_if.source                    rsp_bus,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [srt_pkg::CsrAddrW-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

`include "satellite_record_table_assert.svh"

   localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

   typedef enum logic [1:0] {
      StIdle,
      StScan,
      StPlace,
      StFinish
   } st_type;

   logic [31:0] recycle_ticks;
   logic [31:0] recent_ticks;

   // sequencer state
   st_type           st_ff, st_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic [31:0]      now_ff, now_in;
   logic             query_ff, query_in;
   logic             lim_ok_ff, lim_ok_in;
   logic [31:0]      lim_ff, lim_in;
   srt_pkg::rec_type hold_ff, hold_in;

   // update search results
   logic             hit_ff, hit_in;
   logic [IdxW-1:0]  hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IdxW-1:0]  free_idx_ff, free_idx_in;
   logic             old_ff, old_in;
   logic [IdxW-1:0]  old_idx_ff, old_idx_in;
   logic [31:0]      min_stamp_ff, min_stamp_in;
   logic [IdxW-1:0]  min_idx_ff, min_idx_in;

   // query look-ahead record
   logic             pend_ff, pend_in;
   srt_pkg::rec_type pend_rec_ff, pend_rec_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_has_ff, rsp_has_in;
   srt_pkg::rec_type rsp_rec_ff, rsp_rec_in;
   logic             rsp_last_ff, rsp_last_in;

   // ring
   srt_pkg::cell_ctrl_type cell_ctrl [SLOTS];
   srt_pkg::cell_word_type cell_out [SLOTS];
   srt_pkg::cell_word_type wr_word;
   logic [SLOTS-1:0]       wr_vec;
   logic [IdxW-1:0]        place_idx;

   srt_pkg::cell_word_type head;
   logic                   head_exp;
   logic                   head_vis;
   logic                   can_emit;
   logic                   step_stall;
   logic                   shift;
   logic                   emit;
   logic                   req_go;
   logic [31:0]            dur;

   srt_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .recycle_ticks (recycle_ticks),
      .recent_ticks  (recent_ticks)
   );

   // ring of cells, each loads from the next one, the last from the first
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      assign cell_ctrl[k].shift = shift;
      assign cell_ctrl[k].wr    = wr_vec[k];
      assign wr_vec[k]          = (st_ff == StPlace) && (place_idx == IdxW'(k));

      srt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[k]),
         .nbr_word (cell_out[(k + 1) % SLOTS]),
         .wr_word  (wr_word),
         .word     (cell_out[k])
      );
   end

   // head cell tests against the age limit latched at accept
   assign head       = cell_out[0];
   assign head_exp   = lim_ok_ff && (lim_ff > head.stamp);
   assign head_vis   = head.valid && !head_exp;
   assign can_emit   = !rsp_valid_ff || rsp_bus.ready;
   assign step_stall = query_ff && head_vis && pend_ff && !can_emit;
   assign shift      = (st_ff == StScan) && !step_stall;
   assign req_go     = req_bus.valid && req_bus.ready;
   assign dur        = (req_bus.cmd == srt_pkg::CmdUpdate) ? recycle_ticks : recent_ticks;

   // slot choice for an update: match, then free, then expired, then oldest
   always_comb begin
      if (hit_ff) begin
         place_idx = hit_idx_ff;
      end else if (free_ff) begin
         place_idx = free_idx_ff;
      end else if (old_ff) begin
         place_idx = old_idx_ff;
      end else begin
         place_idx = min_idx_ff;
      end
   end

   assign wr_word.valid = 1'b1;
   assign wr_word.rec   = hold_ff;
   assign wr_word.stamp = now_ff;

   // next-state logic
   always_comb begin
      st_in        = st_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      query_in     = query_ff;
      lim_ok_in    = lim_ok_ff;
      lim_in       = lim_ff;
      hold_in      = hold_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_in       = old_ff;
      old_idx_in   = old_idx_ff;
      min_stamp_in = min_stamp_ff;
      min_idx_in   = min_idx_ff;
      pend_in      = pend_ff;
      pend_rec_in  = pend_rec_ff;
      emit         = 1'b0;
      rsp_has_in   = rsp_has_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;

      case (st_ff)
         StIdle: begin
            if (req_go) begin
               idx_in               = '0;
               lim_ok_in            = dur < now_ff;
               lim_in               = now_ff - dur;
               hold_in.sat_number   = req_bus.sat_number;
               hold_in.elevation    = req_bus.elevation;
               hold_in.azimuth      = req_bus.azimuth;
               hold_in.snr          = req_bus.snr;
               hit_in               = 1'b0;
               free_in              = 1'b0;
               old_in               = 1'b0;
               min_stamp_in         = '1;
               min_idx_in           = '0;
               pend_in              = 1'b0;
               case (srt_pkg::cmd_type'(req_bus.cmd))
                  srt_pkg::CmdTick: begin
                     if (now_ff != '1) begin
                        now_in = now_ff + 32'd1;
                     end
                  end
                  srt_pkg::CmdUpdate: begin
                     st_in    = StScan;
                     query_in = 1'b0;
                  end
                  srt_pkg::CmdQuery: begin
                     st_in    = StScan;
                     query_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         StScan: begin
            if (!step_stall) begin
               if (query_ff) begin
                  // hold one visible record back so the final one can carry last
                  if (head_vis) begin
                     if (pend_ff) begin
                        emit        = 1'b1;
                        rsp_has_in  = 1'b1;
                        rsp_rec_in  = pend_rec_ff;
                        rsp_last_in = 1'b0;
                     end
                     pend_in     = 1'b1;
                     pend_rec_in = head.rec;
                  end
               end else begin
                  if (head.valid && (head.rec.sat_number == hold_ff.sat_number) && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = idx_ff;
                  end
                  if (!head.valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = idx_ff;
                  end
                  if (head_exp && !old_ff) begin
                     old_in     = 1'b1;
                     old_idx_in = idx_ff;
                  end
                  if (head.valid && (head.stamp < min_stamp_ff)) begin
                     min_stamp_in = head.stamp;
                     min_idx_in   = idx_ff;
                  end
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LastIdx) begin
                  st_in = query_ff ? StFinish : StPlace;
               end
            end
         end
         StPlace: begin
            st_in = StIdle;
         end
         StFinish: begin
            if (can_emit) begin
               emit        = 1'b1;
               rsp_has_in  = pend_ff;
               rsp_rec_in  = pend_ff ? pend_rec_ff : '0;
               rsp_last_in = 1'b1;
               pend_in     = 1'b0;
               st_in       = StIdle;
            end
         end
         default: begin
            st_in = StIdle;
         end
      endcase

      // response register
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= StIdle;
         idx_ff       <= '0;
         now_ff       <= '0;
         query_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         idx_ff       <= idx_in;
         now_ff       <= now_in;
         query_ff     <= query_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ok_ff    <= lim_ok_in;
      lim_ff       <= lim_in;
      hold_ff      <= hold_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      old_ff       <= old_in;
      old_idx_ff   <= old_idx_in;
      min_stamp_ff <= min_stamp_in;
      min_idx_ff   <= min_idx_in;
      pend_rec_ff  <= pend_rec_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_rec_ff   <= rsp_rec_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ports
   assign req_bus.ready          = (st_ff == StIdle);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.record_valid   = rsp_has_ff;
   assign rsp_bus.out_sat_number = rsp_rec_ff.sat_number;
   assign rsp_bus.out_elevation  = rsp_rec_ff.elevation;
   assign rsp_bus.out_azimuth    = rsp_rec_ff.azimuth;
   assign rsp_bus.out_snr        = rsp_rec_ff.snr;
   assign rsp_bus.last           = rsp_last_ff;

   // checks
   `SRT_ASSERT_IMP(a_emit_room, clock, reset, emit, !rsp_valid_ff || rsp_bus.ready)
   `SRT_ASSERT_IMP(a_wr_only_place, clock, reset, st_ff != StPlace, wr_vec == '0)
   `SRT_ASSERT_IMP(a_wr_onehot, clock, reset, st_ff == StPlace, $onehot(wr_vec))
   `SRT_ASSERT_NXT(a_now_saturates, clock, reset, now_ff == '1, now_ff == '1)
   `SRT_ASSERT_IMP(a_empty_is_last, clock, reset, rsp_valid_ff && !rsp_has_ff, rsp_last_ff)

endmodule

@@ tb/srt_checker.sv @@
// checker for the satellite record table: keeps its own copy of the table,
// predicts result words from accepted request words and config writes
// depends on srt_pkg, srt_req_if and srt_rsp_if
module srt_checker #(
   parameter int SLOTS = srt_pkg::SlotsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   srt_req_if                           req_mon,
   srt_rsp_if                           rsp_mon,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic                         pready,
   input  logic [srt_pkg::CsrAddrW-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output int                           fail_count,
   output int                           pending
);
   import srt_pkg::*;

   // one predicted result word
   typedef struct packed {
      logic    record_valid;
      rec_type rec;
      logic    last;
   } rsp_word_type;

   localparam logic [31:0] TicksMax = 32'hFFFF_FFFF;

   // mirrored config and table contents
   logic [31:0]  recycle_age;
   logic [31:0]  recent_age;
   logic [31:0]  now_ticks;
   logic         in_use     [SLOTS];
   rec_type      slot_rec   [SLOTS];
   logic [31:0]  slot_stamp [SLOTS];
   rsp_word_type expected_words [$];
   int           errors = 0;

   assign fail_count = errors;

   // a record stamped at stamp is too old against duration dur
   function automatic logic aged_out(input logic [31:0] stamp, input logic [31:0] dur);
      return (dur < now_ticks) && ((now_ticks - dur) > stamp);
   endfunction

   // slot an update lands in: match, then free, then expired, then oldest
   function automatic int pick_slot(input logic [7:0] num);
      int          cand;
      logic [31:0] cand_stamp;
      cand       = 0;
      cand_stamp = TicksMax;
      for (int i = 0; i < SLOTS; i++)
         if (in_use[i] && slot_rec[i].sat_number == num) return i;
      for (int i = 0; i < SLOTS; i++)
         if (!in_use[i]) return i;
      for (int i = 0; i < SLOTS; i++) begin
         if (aged_out(slot_stamp[i], recycle_age)) return i;
         if (in_use[i] && slot_stamp[i] < cand_stamp) begin
            cand       = i;
            cand_stamp = slot_stamp[i];
         end
      end
      return cand;
   endfunction

   // queue every fresh record in slot order, or one empty answer
   task automatic predict_query();
      rsp_word_type w;
      int           found;
      found = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (in_use[i] && !aged_out(slot_stamp[i], recent_age)) begin
            w.record_valid = 1'b1;
            w.rec          = slot_rec[i];
            w.last         = 1'b0;
            expected_words.push_back(w);
            found++;
         end
      end
      if (found == 0) begin
         w      = '0;
         w.last = 1'b1;
         expected_words.push_back(w);
      end else begin
         w      = expected_words.pop_back();
         w.last = 1'b1;
         expected_words.push_back(w);
      end
   endtask

   // advance the mirrored table by one request word
   task automatic apply_request(input logic [1:0] cmd, input rec_type rec);
      int s;
      case (cmd)
         CmdTick: begin
            if (now_ticks != TicksMax) now_ticks = now_ticks + 1;
         end
         CmdUpdate: begin
            s             = pick_slot(rec.sat_number);
            in_use[s]     = 1'b1;
            slot_rec[s]   = rec;
            slot_stamp[s] = now_ticks;
         end
         CmdQuery: predict_query();
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got 'h%0h, expected 'h%0h at %0t", what, got, want, $time);
      errors++;
   endtask

   // compare one result word with the oldest prediction
   task automatic check_word();
      rsp_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("unexpected result word", {31'd0, rsp_mon.record_valid}, 32'd0);
      end else begin
         want = expected_words.pop_front();
         if (rsp_mon.record_valid !== want.record_valid)
            report_mismatch("record_valid", 32'(rsp_mon.record_valid), 32'(want.record_valid));
         if (rsp_mon.out_sat_number !== want.rec.sat_number)
            report_mismatch("out_sat_number", 32'(rsp_mon.out_sat_number),
                            32'(want.rec.sat_number));
         if (rsp_mon.out_elevation !== want.rec.elevation)
            report_mismatch("out_elevation", 32'(unsigned'(rsp_mon.out_elevation)),
                            32'(unsigned'(want.rec.elevation)));
         if (rsp_mon.out_azimuth !== want.rec.azimuth)
            report_mismatch("out_azimuth", 32'(rsp_mon.out_azimuth), 32'(want.rec.azimuth));
         if (rsp_mon.out_snr !== want.rec.snr)
            report_mismatch("out_snr", 32'(rsp_mon.out_snr), 32'(want.rec.snr));
         if (rsp_mon.last !== want.last)
            report_mismatch("last", 32'(rsp_mon.last), 32'(want.last));
      end
   endtask

   // watch config writes, request words and result words
   always @(posedge clock) begin : observe
      rec_type seen;
      if (reset) begin
         recycle_age = RecycleReset;
         recent_age  = RecentReset;
         now_ticks   = '0;
         for (int i = 0; i < SLOTS; i++) in_use[i] = 1'b0;
         expected_words.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[CsrAddrW-1:2]))
               RegRecycle: recycle_age = pwdata;
               RegRecent:  recent_age  = pwdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            seen.sat_number = req_mon.sat_number;
            seen.elevation  = req_mon.elevation;
            seen.azimuth    = req_mon.azimuth;
            seen.snr        = req_mon.snr;
            apply_request(req_mon.cmd, seen);
         end
         if (rsp_mon.valid && rsp_mon.ready) check_word();
      end
      pending <= expected_words.size();
   end

endmodule

@@ tb/tb_top.sv @@
// top of the satellite record table testbench: clock, reset, request and
// config stimulus, result-side stalls, watchdog and verdict
// depends on srt_pkg, srt_req_if, srt_rsp_if, srt_checker and the table itself
module tb_top;
   import srt_pkg::*;

   localparam int         Slots        = SlotsDef;
   localparam int         SettleCycles = 2 * (Slots + 2);
   localparam int         QuietLimit   = 2000;
   localparam int         Phases       = 6;
   localparam int         PhaseWords   = 55;
   localparam logic [1:0] CmdIgnored   = 2'd3;

   typedef enum int {
      StallNone,
      StallLight,
      StallHeavy,
      StallToggle
   } stall_mode_type;

   typedef struct packed {
      logic [1:0] cmd;
      rec_type    rec;
   } req_word_type;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;
   int                  fail_count;
   int                  pending;
   int                  quiet_cycles = 0;

   srt_req_if req_bus ();
   srt_rsp_if rsp_bus ();

   satellite_record_table #(.SLOTS(Slots)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   srt_checker #(.SLOTS(Slots)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no word moving and no config access
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side stalls in stretches of changing style
   initial begin
      stall_mode_type mode;
      int             span;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(4, 40);
         repeat (span) begin
            case (mode)
               StallNone:  rsp_bus.ready <= 1'b1;
               StallLight: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               StallHeavy: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:    rsp_bus.ready <= ~rsp_bus.ready;
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic req_word_type make_word(input logic [1:0] cmd, input int sat,
                                              input int elev, input int az, input int snr);
      req_word_type w;
      w.cmd            = cmd;
      w.rec.sat_number = 8'(sat);
      w.rec.elevation  = 8'(elev);
      w.rec.azimuth    = 9'(az);
      w.rec.snr        = 7'(snr);
      return w;
   endfunction

   // mostly in-range records on a small set of satellite numbers
   function automatic req_word_type random_word(input int pool);
      req_word_type w;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      w.cmd = CmdTick;
      else if (pick < 75) w.cmd = CmdUpdate;
      else if (pick < 95) w.cmd = CmdQuery;
      else                w.cmd = CmdIgnored;
      w.rec.sat_number = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, pool - 1))
                                                      : 8'($urandom);
      w.rec.elevation  = ($urandom_range(0, 5) != 0) ? 8'(int'($urandom_range(0, 180)) - 90)
                                                      : 8'($urandom);
      w.rec.azimuth    = ($urandom_range(0, 5) != 0) ? 9'($urandom_range(0, 359))
                                                      : 9'($urandom);
      w.rec.snr        = ($urandom_range(0, 5) != 0) ? 7'($urandom_range(0, 99))
                                                      : 7'($urandom);
      return w;
   endfunction

   // present one request word and hold it until taken
   task automatic send_word(input req_word_type w);
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= w.cmd;
      req_bus.sat_number <= w.rec.sat_number;
      req_bus.elevation  <= w.rec.elevation;
      req_bus.azimuth    <= w.rec.azimuth;
      req_bus.snr        <= w.rec.snr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // stop sending until every predicted word is back and the table is idle
   task automatic drain_table();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // setup then access cycle, then release of the port
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrW'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // field extremes, matching update, ignored code, empty table
   task automatic run_directed();
      send_word(make_word(CmdQuery, 0, 0, 0, 0));
      send_word(make_word(CmdIgnored, 255, -1, 511, 127));
      send_word(make_word(CmdUpdate, 0, -90, 0, 0));
      send_word(make_word(CmdUpdate, 255, 90, 359, 99));
      send_word(make_word(CmdUpdate, 128, -128, 511, 127));
      send_word(make_word(CmdUpdate, 127, 127, 360, 100));
      send_word(make_word(CmdQuery, 255, 127, 511, 127));
      send_word(make_word(CmdUpdate, 0, 45, 180, 50));
      send_word(make_word(CmdTick, 255, -1, 511, 127));
      send_word(make_word(CmdTick, 0, 0, 0, 0));
      send_word(make_word(CmdQuery, 0, 0, 0, 0));
      send_word(make_word(CmdIgnored, 7, 10, 20, 30));
      send_word(make_word(CmdUpdate, 1, 0, 1, 1));
      send_word(make_word(CmdTick, 0, 0, 0, 0));
      send_word(make_word(CmdQuery, 0, 0, 0, 0));
   endtask

   // bursts of random words, one full drain halfway through
   task automatic run_random(input int words, input int pool, input bit gaps);
      int sent;
      int burst;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < words) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < words; k++) begin
            send_word(random_word(pool));
            sent++;
         end
         if (!paused && sent >= words / 2) begin
            paused = 1'b1;
            drain_table();
         end else if (gaps) begin
            hold_off($urandom_range(0, 6));
         end
      end
   endtask

   // main sequence
   initial begin
      logic [31:0] recycle_plan [Phases];
      logic [31:0] recent_plan  [Phases];
      recycle_plan = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, 32'd0};
      recent_plan  = '{32'd0, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0};
      recycle_plan[Phases-1] = $urandom_range(0, 30);
      recent_plan[Phases-1]  = $urandom_range(0, 30);

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CmdTick;
      req_bus.sat_number <= '0;
      req_bus.elevation  <= '0;
      req_bus.azimuth    <= '0;
      req_bus.snr        <= '0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain_table();

      for (int p = 0; p < Phases; p++) begin
         csr_write(RegRecycle, recycle_plan[p]);
         csr_write(RegRecent, recent_plan[p]);
         run_random(PhaseWords, $urandom_range(12, 26), (p % 3) != 1);
         drain_table();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
